[sv/l3d_pkg.sv]
// shared types and constants for the 3d lut color map
`timescale 1ns / 1ps
package l3d_pkg;
   localparam int MAX_DIM_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int REG_W = 7;
   localparam int IDX_W = 18;
   localparam int ENTRY_W = 24;

   localparam logic [1:0] CSR_LUT_DIM = 2'd0;
   localparam logic [1:0] CSR_BLEND = 2'd1;
   localparam logic [1:0] CSR_DEEP = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   localparam logic [REG_W-1:0] LUT_DIM_RESET = 7'd64;
   localparam logic [REG_W-1:0] BLEND_RESET = 7'd100;
   localparam logic [REG_W-1:0] PCT_FULL = 7'd100;

   // floor(v / 257) for 16-bit v, floor(s / 100) for 23-bit s
   localparam logic [16:0] RECIP_257 = 17'd65281;
   localparam logic [23:0] RECIP_100 = 24'd10737419;

   typedef struct packed {
      logic [REG_W-1:0]   dim;
      logic [2*REG_W-1:0] dim_sq;
      logic [REG_W-1:0]   pct;
      logic               deep;
   } cfg_type;
endpackage

[sv/l3d_ram.sv]
// generic single write, dual read ram with registered read data
`timescale 1ns / 1ps
module l3d_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;
endmodule

[sv/l3d_front.sv]
// front end: accepts beats, splits pixels into cell and fraction, forms the base index
`timescale 1ns / 1ps
module l3d_front #(
   parameter int MAX_DIM = 64,
   parameter int AW = 18,
   parameter int CW = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  l3d_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [17:0]           req_entry_index,
   input  logic [7:0]            req_entry_red,
   input  logic [7:0]            req_entry_green,
   input  logic [7:0]            req_entry_blue,
   input  logic [15:0]           req_pixel_red,
   input  logic [15:0]           req_pixel_green,
   input  logic [15:0]           req_pixel_blue,
   output logic                  ent_valid,
   input  logic                  ent_ready,
   output logic                  ent_op,
   output logic [AW-1:0]         ent_addr,
   output logic [23:0]           ent_wdata,
   output logic [2:0][15:0]      ent_frac,
   output logic [2:0][15:0]      ent_px
);
   import l3d_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W + 1)'(DEPTH);

   logic                 en;
   logic                 write_ok;
   logic                 f1_valid_in;
   logic [REG_W-1:0]     dm1;
   logic [2:0][15:0]     pix;
   logic [2:0][15:0]     px_m;
   logic [2:0][22:0]     prod;
   logic [2:0][22:0]     tcoord;
   logic [2:0][CW-1:0]   grid_pos;
   logic [2:0][15:0]     frac;
   logic [AW-1:0]        base;

   logic                 f1_valid_ff;
   logic                 f1_op_ff;
   logic [AW-1:0]        f1_addr_ff;
   logic [23:0]          f1_wdata_ff;
   logic [2:0][CW-1:0]   f1_cell_ff;
   logic [2:0][15:0]     f1_frac_ff;
   logic [2:0][15:0]     f1_px_ff;

   logic                 f2_valid_ff;
   logic                 f2_op_ff;
   logic [AW-1:0]        f2_addr_ff;
   logic [23:0]          f2_wdata_ff;
   logic [2:0][15:0]     f2_frac_ff;
   logic [2:0][15:0]     f2_px_ff;

   assign pix = {req_pixel_blue, req_pixel_green, req_pixel_red};

   always_comb begin
      dm1 = cfg.dim - 7'd1;
      for (int ch = 0; ch < 3; ch++) begin
         px_m[ch] = cfg.deep ? pix[ch] : {8'h00, pix[ch][7:0]};
         prod[ch] = 23'(px_m[ch]) * 23'(dm1);
         tcoord[ch] = cfg.deep ? prod[ch] : {prod[ch][14:0], 8'h00};
         grid_pos[ch] = tcoord[ch][16 +: CW];
         frac[ch] = tcoord[ch][15:0];
      end
   end

   assign write_ok = {1'b0, req_entry_index} < DEPTH_LIM;
   assign f1_valid_in = req_valid && (req_operation == OP_PIXEL || write_ok);

   assign base = AW'(f1_cell_ff[0])
               + AW'(AW'(f1_cell_ff[2]) * AW'(cfg.dim))
               + AW'(AW'(f1_cell_ff[1]) * AW'(cfg.dim_sq));

   assign en = !f2_valid_ff || ent_ready;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= f1_valid_in;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_op_ff    <= req_operation;
         f1_addr_ff  <= req_entry_index[AW-1:0];
         f1_wdata_ff <= {req_entry_red, req_entry_green, req_entry_blue};
         f1_cell_ff  <= grid_pos;
         f1_frac_ff  <= frac;
         f1_px_ff    <= px_m;
         f2_op_ff    <= f1_op_ff;
         f2_addr_ff  <= (f1_op_ff == OP_PIXEL) ? base : f1_addr_ff;
         f2_wdata_ff <= f1_wdata_ff;
         f2_frac_ff  <= f1_frac_ff;
         f2_px_ff    <= f1_px_ff;
      end
   end

   assign ent_valid = f2_valid_ff;
   assign ent_op    = f2_op_ff;
   assign ent_addr  = f2_addr_ff;
   assign ent_wdata = f2_wdata_ff;
   assign ent_frac  = f2_frac_ff;
   assign ent_px    = f2_px_ff;
endmodule

[sv/l3d_queue.sv]
// short fifo between front and back end
`timescale 1ns / 1ps
module l3d_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW:0] FULL = (PW + 1)'(DEPTH);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = count_ff != FULL;
   assign pop_valid  = count_ff != '0;
   assign push_fire  = push && push_ready;
   assign pop_fire   = pop && pop_valid;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL)
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");
   assert property (@(posedge clock) disable iff (reset)
      (pop_fire && !push_fire) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count missed a pop");
endmodule

[sv/l3d_back.sv]
// back end: table banks, trilinear interpolation, depth rescale and blend
`timescale 1ns / 1ps
module l3d_back #(
   parameter int MAX_DIM = 64,
   parameter int AW = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  l3d_pkg::cfg_type   cfg,
   input  logic               ent_valid,
   output logic               ent_pop,
   input  logic               ent_op,
   input  logic [AW-1:0]      ent_addr,
   input  logic [23:0]        ent_wdata,
   input  logic [2:0][15:0]   ent_frac,
   input  logic [2:0][15:0]   ent_px,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_mapped_red,
   output logic [15:0]        rsp_mapped_green,
   output logic [15:0]        rsp_mapped_blue
);
   import l3d_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;

   logic                en;
   logic                wr_en;
   logic [3:0][AW-1:0]  rd_addr_a;
   logic [3:0][AW-1:0]  rd_addr_b;
   logic [3:0][23:0]    rd_data_a;
   logic [3:0][23:0]    rd_data_b;
   logic [AW-1:0]       sb;
   logic [AW-1:0]       sg;

   logic [2:0][15:0]    a2 [4];
   logic [2:0][15:0]    b2 [4];
   logic signed [16:0]  d2 [3][4];
   logic signed [33:0]  p2 [3][4];
   logic [31:0]         r2_in [3][4];
   logic signed [32:0]  d3 [3][2];
   logic signed [49:0]  p3 [3][2];
   logic [47:0]         b3_in [3][2];
   logic signed [48:0]  d4 [3];
   logic signed [65:0]  p4 [3];
   logic [65:0]         sum4 [3];
   logic [2:0][15:0]    v4_in;
   logic [32:0]         m5 [3];
   logic [2:0][15:0]    w5_in;
   logic [2:0][22:0]    s6_in;
   logic [46:0]         q7 [3];
   logic [2:0][15:0]    out_in;

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic                out_valid_ff;
   logic [2:0][15:0]    frac1_ff, frac2_ff, frac3_ff;
   logic [2:0][15:0]    px1_ff, px2_ff, px3_ff, px4_ff, px5_ff;
   logic [31:0]         r2_ff [3][4];
   logic [47:0]         b3_ff [3][2];
   logic [2:0][15:0]    val4_ff;
   logic [2:0][15:0]    w5_ff;
   logic [2:0][22:0]    s6_ff;
   logic [2:0][15:0]    out_ff;

   assign en      = !out_valid_ff || !rsp_stall;
   assign ent_pop = ent_valid && en;
   assign wr_en   = ent_pop && ent_op == OP_WRITE;

   // bank k holds a full copy, read at the two red neighbors of one blue/green corner
   assign sb = AW'(cfg.dim);
   assign sg = AW'(cfg.dim_sq);

   always_comb begin
      rd_addr_a[0] = ent_addr;
      rd_addr_a[1] = ent_addr + sb;
      rd_addr_a[2] = ent_addr + sg;
      rd_addr_a[3] = ent_addr + sg + sb;
      for (int k = 0; k < 4; k++) begin
         rd_addr_b[k] = rd_addr_a[k] + 1'b1;
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_bank
      l3d_ram #(
         .WIDTH (ENTRY_W),
         .DEPTH (DEPTH)
      ) u_bank (
         .clock     (clock),
         .wr_en     (wr_en),
         .wr_addr   (ent_addr),
         .wr_data   (ent_wdata),
         .rd_en     (en),
         .rd_addr_a (rd_addr_a[k]),
         .rd_addr_b (rd_addr_b[k]),
         .rd_data_a (rd_data_a[k]),
         .rd_data_b (rd_data_b[k])
      );
   end

   // red axis
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int ch = 0; ch < 3; ch++) begin
            a2[k][ch] = {2{rd_data_a[k][23 - 8 * ch -: 8]}};
            b2[k][ch] = {2{rd_data_b[k][23 - 8 * ch -: 8]}};
            d2[ch][k] = $signed({1'b0, b2[k][ch]}) - $signed({1'b0, a2[k][ch]});
            p2[ch][k] = d2[ch][k] * $signed({1'b0, frac1_ff[0]});
            r2_in[ch][k] = 32'($signed({2'b00, a2[k][ch], 16'h0000}) + p2[ch][k]);
         end
      end
   end

   // blue axis
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int j = 0; j < 2; j++) begin
            d3[ch][j] = $signed({1'b0, r2_ff[ch][2*j+1]}) - $signed({1'b0, r2_ff[ch][2*j]});
            p3[ch][j] = d3[ch][j] * $signed({1'b0, frac2_ff[2]});
            b3_in[ch][j] = 48'($signed({2'b00, r2_ff[ch][2*j], 16'h0000}) + p3[ch][j]);
         end
      end
   end

   // green axis, then depth rescale, blend and divide by 100
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         d4[ch] = $signed({1'b0, b3_ff[ch][1]}) - $signed({1'b0, b3_ff[ch][0]});
         p4[ch] = d4[ch] * $signed({1'b0, frac3_ff[1]});
         sum4[ch] = 66'($signed({2'b00, b3_ff[ch][0], 16'h0000}) + p4[ch]);
         v4_in[ch] = sum4[ch][64] ? 16'hFFFF : sum4[ch][63:48];
         m5[ch] = 33'(val4_ff[ch]) * 33'(RECIP_257);
         w5_in[ch] = cfg.deep ? val4_ff[ch] : {8'h00, m5[ch][31:24]};
         s6_in[ch] = 23'(PCT_FULL - cfg.pct) * 23'(px5_ff[ch]) + 23'(cfg.pct) * 23'(w5_ff[ch]);
         q7[ch] = 47'(s6_ff[ch]) * 47'(RECIP_100);
         out_in[ch] = q7[ch][45:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= ent_pop && ent_op == OP_PIXEL;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         out_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         frac1_ff   <= ent_frac;
         px1_ff     <= ent_px;
         frac2_ff   <= frac1_ff;
         px2_ff     <= px1_ff;
         r2_ff      <= r2_in;
         frac3_ff   <= frac2_ff;
         px3_ff     <= px2_ff;
         b3_ff      <= b3_in;
         px4_ff     <= px3_ff;
         val4_ff    <= v4_in;
         px5_ff     <= px4_ff;
         w5_ff      <= w5_in;
         s6_ff      <= s6_in;
         out_ff     <= out_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mapped_red   = out_ff[0];
   assign rsp_mapped_green = out_ff[1];
   assign rsp_mapped_blue  = out_ff[2];
endmodule

[sv/lut3d_trilinear_color_map.sv]
// top level of the 3d lut trilinear color map
`timescale 1ns / 1ps
// grades pixels through a cubic color table of lut_dim points per axis.
// req channel: a beat with operation write stores one table entry at
// entry_index (ignored past the table end); a beat with operation pixel maps
// pixel_red/green/blue and yields exactly one rsp beat. results leave in order.
// csr port: csr_write with csr_index 0 lut_dim, 1 blend_percent, 2 deep_color;
// write only while no beat is in flight.
// a pixel passes two front stages, the queue, the table read, three
// interpolation stages, rescale, blend and divide, in that order.
// throughput: one beat per cycle on both channels when nothing stalls; the four
// table banks each serve two of the eight corners from the same read.
// reset: control clears, registers go to dim 64, blend 100, 8-bit mode; the
// table content is undefined until written.
// rsp_stall while rsp_valid is high freezes the back pipeline; the four-deep queue and front stages
// keep taking req beats until they fill, then req_stall rises.
module lut3d_trilinear_color_map #(
   parameter int MAX_DIM = l3d_pkg::MAX_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [17:0] req_entry_index,
   input  logic [7:0]  req_entry_red,
   input  logic [7:0]  req_entry_green,
   input  logic [7:0]  req_entry_blue,
   input  logic [15:0] req_pixel_red,
   input  logic [15:0] req_pixel_green,
   input  logic [15:0] req_pixel_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_mapped_red,
   output logic [15:0] rsp_mapped_green,
   output logic [15:0] rsp_mapped_blue
);
   import l3d_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(MAX_DIM);
   localparam int QW = 1 + AW + ENTRY_W + 96;
   localparam logic [REG_W-1:0] DIM_MAX = REG_W'(MAX_DIM);
   localparam logic [REG_W-1:0] DIM_MIN = 7'd2;

   logic [REG_W-1:0]   lut_dim_ff;
   logic [REG_W-1:0]   blend_percent_ff;
   logic               deep_color_ff;
   logic [2*REG_W-1:0] dim_sq_ff;
   logic [REG_W-1:0]   dim_clamped;
   cfg_type            cfg;

   logic               ent_valid, ent_ready, ent_op;
   logic [AW-1:0]      ent_addr;
   logic [23:0]        ent_wdata;
   logic [2:0][15:0]   ent_frac, ent_px;
   logic               q_valid, q_pop, q_op;
   logic [AW-1:0]      q_addr;
   logic [23:0]        q_wdata;
   logic [2:0][15:0]   q_frac, q_px;
   logic [QW-1:0]      q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         lut_dim_ff       <= LUT_DIM_RESET;
         blend_percent_ff <= BLEND_RESET;
         deep_color_ff    <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LUT_DIM: lut_dim_ff <= csr_data;
            CSR_BLEND:   blend_percent_ff <= csr_data;
            CSR_DEEP:    deep_color_ff <= csr_data[0];
            default:     ;
         endcase
      end
   end

   assign dim_clamped = (lut_dim_ff < DIM_MIN) ? DIM_MIN :
                        (lut_dim_ff > DIM_MAX) ? DIM_MAX : lut_dim_ff;

   always_ff @(posedge clock) begin
      dim_sq_ff <= (2 * REG_W)'(dim_clamped) * (2 * REG_W)'(dim_clamped);
   end

   always_comb begin
      cfg.dim    = dim_clamped;
      cfg.dim_sq = dim_sq_ff;
      cfg.pct    = (blend_percent_ff > PCT_FULL) ? PCT_FULL : blend_percent_ff;
      cfg.deep   = deep_color_ff;
   end

   l3d_front #(
      .MAX_DIM (MAX_DIM),
      .AW      (AW),
      .CW      (CW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .ent_valid       (ent_valid),
      .ent_ready       (ent_ready),
      .ent_op          (ent_op),
      .ent_addr        (ent_addr),
      .ent_wdata       (ent_wdata),
      .ent_frac        (ent_frac),
      .ent_px          (ent_px)
   );

   l3d_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (ent_valid),
      .push_ready (ent_ready),
      .push_data  ({ent_op, ent_addr, ent_wdata, ent_frac, ent_px}),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   assign {q_op, q_addr, q_wdata, q_frac, q_px} = q_data;

   l3d_back #(
      .MAX_DIM (MAX_DIM),
      .AW      (AW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .ent_valid        (q_valid),
      .ent_pop          (q_pop),
      .ent_op           (q_op),
      .ent_addr         (q_addr),
      .ent_wdata        (q_wdata),
      .ent_frac         (q_frac),
      .ent_px           (q_px),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mapped_red   (rsp_mapped_red),
      .rsp_mapped_green (rsp_mapped_green),
      .rsp_mapped_blue  (rsp_mapped_blue)
   );
endmodule
